>>> rtl/sorted_insert_priority_queue_top_defines.svh
// assertion helpers used by the queue engine rtl
`ifndef SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define SIPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sipq assertion failed");

// next-cycle implication, sampled on aclk, off while aresetn is low
`define SIPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sipq assertion failed");

`endif

>>> rtl/sipq_pkg.sv
package sipq_pkg;

    // operation codes of the input kind field
    localparam logic KIND_ADD    = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // register map
    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [4:0] CAP_RESET    = 5'd16;

    // input transaction payload
    typedef struct packed {
        logic       kind;
        logic [7:0] item_prio;
        logic [7:0] item_char;
    } sipq_in_t;

    // result transaction payload
    typedef struct packed {
        logic [7:0] out_prio;
        logic [7:0] out_char;
        logic [1:0] status;
        logic [4:0] count;
    } sipq_out_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_WR,
        ST_REM_RD,
        ST_REM_DAT,
        ST_DONE
    } sipq_state_t;

endpackage

>>> rtl/sorted_insert_priority_queue_top.sv
// add: compares stored entries from the tail toward the head, at most the count, then writes
// remove: reads the head slot; a refused add or remove goes straight to the result stage
// one item at a time; each insert step is a memory read then a compare and write of one slot
// result goes to an output register, so the sequencer frees up while it waits to be taken
// reset (aresetn low, synchronous): queue empty, pointers zero, capacity 16, slots undefined
module sorted_insert_priority_queue_top #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sipq_pkg::sipq_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sipq_pkg::sipq_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [4:0]          capacity_reg, capacity_next;
    logic                out_valid_reg, out_valid_next;
    sipq_pkg::sipq_out_t out_data_reg, out_data_next;
    logic                res_valid;
    logic                res_ready;
    sipq_pkg::sipq_out_t res_data;
    logic                cfg_write;

    sipq_engine #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .capacity  (capacity_reg)
    );

    // configuration register write
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == sipq_pkg::REG_CAPACITY);

    always_comb begin
        capacity_next = capacity_reg;
        if (cfg_write) begin
            capacity_next = pwdata[4:0];
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        if (paddr[2] == sipq_pkg::REG_CAPACITY) begin
            prdata = {27'b0, capacity_reg};
        end
    end

    // output register for the result transaction
    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= sipq_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            capacity_reg  <= capacity_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

>>> rtl/sipq_slot_ram.sv
module sipq_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] slot_mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port
    always_ff @(posedge aclk) begin
        if (we) begin
            slot_mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= slot_mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/sipq_engine.sv
`include "sorted_insert_priority_queue_top_defines.svh"

module sipq_engine #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sipq_pkg::sipq_in_t   in_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output sipq_pkg::sipq_out_t  res_data,
    input  logic [4:0]           capacity
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;
    localparam int SW   = PRIO_BITS + 8;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

    sipq_pkg::sipq_state_t state_reg, state_next;

    logic [AW-1:0]        head_reg, head_next;
    logic [AW-1:0]        tail_reg, tail_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        moved_reg, moved_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [7:0]           char_reg, char_next;
    logic [7:0]           res_prio_reg, res_prio_next;
    logic [7:0]           res_char_reg, res_char_next;
    logic [1:0]           status_reg, status_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [SW-1:0]        ram_rdata;

    logic [PRIO_BITS-1:0] rd_prio;
    logic [7:0]           rd_char;
    logic [39:0]          in_prio_wide;
    logic [39:0]          rd_prio_wide;
    logic [CMPW-1:0]      count_wide;
    logic [CMPW-1:0]      cap_wide;
    logic [CMPW-1:0]      eff_cap;
    logic                 is_full;
    logic                 is_empty;
    logic                 larger;
    logic [CW-1:0]        moved_inc;
    logic [AW-1:0]        pos_prev;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] idx);
        slot_inc = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] idx);
        slot_dec = (idx == '0) ? LAST_SLOT : idx - 1'b1;
    endfunction

    sipq_slot_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SW)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // occupancy checks against the saturated capacity
    assign count_wide = CMPW'(count_reg);
    assign cap_wide   = CMPW'(capacity);
    assign eff_cap    = (cap_wide > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_wide;
    assign is_full    = (count_wide >= eff_cap);
    assign is_empty   = (count_reg == '0);

    // shared compare unit: stored neighbor against the entry being placed
    assign rd_prio   = ram_rdata[SW-1:8];
    assign rd_char   = ram_rdata[7:0];
    assign larger    = (rd_prio > prio_reg);
    assign moved_inc = moved_reg + 1'b1;
    assign pos_prev  = slot_dec(pos_reg);

    assign in_prio_wide = {32'b0, in_data.item_prio};
    assign rd_prio_wide = 40'(rd_prio);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sipq_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (in_data.kind == sipq_pkg::KIND_ADD) begin
                        if (is_full) begin
                            state_next = sipq_pkg::ST_DONE;
                        end else if (is_empty) begin
                            state_next = sipq_pkg::ST_ADD_WR;
                        end else begin
                            state_next = sipq_pkg::ST_ADD_RD;
                        end
                    end else begin
                        state_next = is_empty ? sipq_pkg::ST_DONE : sipq_pkg::ST_REM_RD;
                    end
                end
            end
            sipq_pkg::ST_ADD_RD: begin
                state_next = sipq_pkg::ST_ADD_CMP;
            end
            sipq_pkg::ST_ADD_CMP: begin
                if (larger && (moved_inc < count_reg)) begin
                    state_next = sipq_pkg::ST_ADD_RD;
                end else begin
                    state_next = sipq_pkg::ST_ADD_WR;
                end
            end
            sipq_pkg::ST_ADD_WR: begin
                state_next = sipq_pkg::ST_DONE;
            end
            sipq_pkg::ST_REM_RD: begin
                state_next = sipq_pkg::ST_REM_DAT;
            end
            sipq_pkg::ST_REM_DAT: begin
                state_next = sipq_pkg::ST_DONE;
            end
            sipq_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = sipq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sipq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and memory control per state
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        moved_next    = moved_reg;
        prio_next     = prio_reg;
        char_next     = char_reg;
        res_prio_next = res_prio_reg;
        res_char_next = res_char_reg;
        status_next   = status_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = {prio_reg, char_reg};
        ram_raddr     = pos_prev;
        case (state_reg)
            sipq_pkg::ST_IDLE: begin
                if (in_valid) begin
                    prio_next     = in_prio_wide[PRIO_BITS-1:0];
                    char_next     = in_data.item_char;
                    pos_next      = tail_reg;
                    moved_next    = '0;
                    res_prio_next = '0;
                    res_char_next = '0;
                    status_next   = sipq_pkg::STAT_OK;
                    if (in_data.kind == sipq_pkg::KIND_ADD) begin
                        if (is_full) begin
                            status_next = sipq_pkg::STAT_FULL;
                        end
                    end else if (is_empty) begin
                        status_next = sipq_pkg::STAT_EMPTY;
                    end
                end
            end
            sipq_pkg::ST_ADD_CMP: begin
                // shift the larger neighbor one slot toward the tail
                if (larger) begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg;
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_prev;
                    moved_next = moved_inc;
                end
            end
            sipq_pkg::ST_ADD_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg;
                ram_wdata  = {prio_reg, char_reg};
                tail_next  = slot_inc(tail_reg);
                count_next = count_reg + 1'b1;
            end
            sipq_pkg::ST_REM_RD: begin
                ram_raddr = head_reg;
            end
            sipq_pkg::ST_REM_DAT: begin
                res_prio_next = rd_prio_wide[7:0];
                res_char_next = rd_char;
                count_next    = count_reg - 1'b1;
                if (count_reg == CW'(1)) begin
                    head_next = '0;
                    tail_next = '0;
                end else begin
                    head_next = slot_inc(head_reg);
                end
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sipq_pkg::ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // working and result registers
    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        moved_reg    <= moved_next;
        prio_reg     <= prio_next;
        char_reg     <= char_next;
        res_prio_reg <= res_prio_next;
        res_char_reg <= res_char_next;
        status_reg   <= status_next;
    end

    assign in_ready          = (state_reg == sipq_pkg::ST_IDLE);
    assign res_valid         = (state_reg == sipq_pkg::ST_DONE);
    assign res_data.out_prio = res_prio_reg;
    assign res_data.out_char = res_char_reg;
    assign res_data.status   = status_reg;
    assign res_data.count    = count_wide[4:0];

    `SIPQ_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(DEPTH))
    `SIPQ_ASSERT_IMP(a_empty_ptrs, count_reg == '0, head_reg == '0 && tail_reg == '0)
    `SIPQ_ASSERT_IMP(a_ready_idle, in_ready, state_reg == sipq_pkg::ST_IDLE)
    `SIPQ_ASSERT_NXT(a_done_idle, res_valid && res_ready, state_reg == sipq_pkg::ST_IDLE)

endmodule

>>> bench/sorted_insert_priority_queue_top_test.sv
module sorted_insert_priority_queue_top_test;

    localparam int DEPTH = 16;
    localparam logic [2:0] ADDR_CAPACITY = {sipq_pkg::REG_CAPACITY, 2'b00};
    // index 1 holds no register, writes there must be ignored
    localparam logic [2:0] ADDR_SPARE = 3'd4;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    sipq_pkg::sipq_in_t s_data;
    logic m_valid;
    logic m_ready;
    sipq_pkg::sipq_out_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    // shadow of the queue contents and the capacity register
    logic [7:0] shadow_prio [DEPTH];
    logic [7:0] shadow_char [DEPTH];
    int unsigned shadow_head;
    int unsigned shadow_tail;
    int unsigned shadow_count;
    logic [4:0] shadow_capacity;

    sipq_pkg::sipq_out_t expected_results[$];
    int unsigned mismatch_count;
    bit calm;

    sorted_insert_priority_queue_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #6 aclk = ~aclk;

    // result side stalls at random unless in a calm stretch
    always @(negedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 14);
    end

    // apply one operation to the shadow queue and return the result it should give
    function automatic sipq_pkg::sipq_out_t predict_queue_result(input sipq_pkg::sipq_in_t op);
        sipq_pkg::sipq_out_t res;
        int unsigned limit;
        int unsigned pos;
        int unsigned prv;
        int unsigned moved;
        logic [7:0] tmp_prio;
        logic [7:0] tmp_char;
        res = '0;
        limit = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
        if (op.kind == sipq_pkg::KIND_ADD) begin
            if (shadow_count >= limit) begin
                res.status = sipq_pkg::STAT_FULL;
            end else begin
                pos = shadow_tail;
                shadow_prio[pos] = op.item_prio;
                shadow_char[pos] = op.item_char;
                moved = 0;
                // bubble toward the head past strictly larger priority numbers
                while (moved < shadow_count) begin
                    prv = (pos == 0) ? DEPTH - 1 : pos - 1;
                    if (shadow_prio[prv] <= op.item_prio)
                        break;
                    tmp_prio = shadow_prio[prv];
                    tmp_char = shadow_char[prv];
                    shadow_prio[prv] = shadow_prio[pos];
                    shadow_char[prv] = shadow_char[pos];
                    shadow_prio[pos] = tmp_prio;
                    shadow_char[pos] = tmp_char;
                    pos = prv;
                    moved++;
                end
                shadow_tail = (shadow_tail + 1 >= DEPTH) ? 0 : shadow_tail + 1;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = sipq_pkg::STAT_EMPTY;
            end else begin
                res.out_prio = shadow_prio[shadow_head];
                res.out_char = shadow_char[shadow_head];
                shadow_count--;
                // last entry gone: pointers return to zero
                if (shadow_count == 0) begin
                    shadow_head = 0;
                    shadow_tail = 0;
                end else begin
                    shadow_head = (shadow_head + 1 >= DEPTH) ? 0 : shadow_head + 1;
                end
            end
        end
        res.count = 5'(shadow_count);
        return res;
    endfunction

    // compare results in order, then record a prediction for each accepted operation
    always @(posedge aclk) begin : result_check
        sipq_pkg::sipq_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no operation outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.out_prio !== want.out_prio) begin
                        $error("out_prio: expected %0d, actual %0d", want.out_prio,
                            m_data.out_prio);
                        mismatch_count++;
                    end
                    if (m_data.out_char !== want.out_char) begin
                        $error("out_char: expected %0d, actual %0d", want.out_char,
                            m_data.out_char);
                        mismatch_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status,
                            m_data.status);
                        mismatch_count++;
                    end
                    if (m_data.count !== want.count) begin
                        $error("count: expected %0d, actual %0d", want.count,
                            m_data.count);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_queue_result(s_data));
        end
    end

    function automatic sipq_pkg::sipq_in_t make_op(input logic kind, input logic [7:0] prio,
                                                   input logic [7:0] ch);
        sipq_pkg::sipq_in_t op;
        op.kind = kind;
        op.item_prio = prio;
        op.item_char = ch;
        return op;
    endfunction

    // present one operation; valid stays high afterwards so the next can follow directly
    task automatic send_op(input sipq_pkg::sipq_in_t op);
        while (!calm && $urandom_range(99) < 14) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = op;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    // stop sending and wait until every outstanding result has been taken
    task automatic wait_drained();
        s_valid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // register write: setup cycle, then access cycle
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        wait_drained();
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if ((addr >> 2) == sipq_pkg::REG_CAPACITY)
            shadow_capacity = data[4:0];
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // field extremes, equal priorities, emptying and removes from an empty queue
    task automatic test_directed_ops();
        send_op(make_op(sipq_pkg::KIND_REMOVE, 8'h00, 8'h00));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h80, 8'h11));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'hff, 8'hff));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h00, 8'h00));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h80, 8'h22));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h00, 8'ha5));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'hff, 8'h01));
        repeat (6) send_op(make_op(sipq_pkg::KIND_REMOVE, 8'hff, 8'hff));
        send_op(make_op(sipq_pkg::KIND_REMOVE, 8'h00, 8'h00));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h40, 8'h5a));
        send_op(make_op(sipq_pkg::KIND_REMOVE, 8'h00, 8'h00));
    endtask

    // zero and one slot capacity, and a write to an unmapped index
    task automatic test_capacity_limits();
        write_reg(ADDR_CAPACITY, 32'd0);
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h10, 8'h20));
        send_op(make_op(sipq_pkg::KIND_REMOVE, 8'h00, 8'h00));
        write_reg(ADDR_CAPACITY, 32'hffff_ffe1);
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h7f, 8'h01));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h01, 8'h02));
        send_op(make_op(sipq_pkg::KIND_REMOVE, 8'h00, 8'h00));
        write_reg(ADDR_SPARE, 32'd0);
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h33, 8'h44));
        send_op(make_op(sipq_pkg::KIND_ADD, 8'h22, 8'h55));
        send_op(make_op(sipq_pkg::KIND_REMOVE, 8'h00, 8'h00));
    endtask

    // phases of fill, drain and mixed traffic under changing capacity
    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned len;
        int unsigned add_pct;
        int unsigned sent;
        int unsigned r;
        logic [4:0] cap;
        sipq_pkg::sipq_in_t op;
        phase = 0;
        sent = 0;
        while (sent < 900) begin
            // capacity changes only between phases, the queue may still hold entries
            if (phase < 3 || $urandom_range(99) < 70) begin
                r = $urandom_range(19);
                if (phase == 1)
                    cap = 5'd31;
                else if (phase == 2)
                    cap = 5'd1;
                else if (r == 0)
                    cap = 5'd0;
                else if (r < 4)
                    cap = 5'($urandom_range(31, 17));
                else if (r < 8)
                    cap = 5'd16;
                else
                    cap = 5'($urandom_range(15, 1));
                write_reg(ADDR_CAPACITY, ($urandom() & ~32'h1f) | 32'(cap));
            end
            case ($urandom_range(2))
                0: add_pct = 80;
                1: add_pct = 50;
                default: add_pct = 20;
            endcase
            if (phase == 1)
                add_pct = 85;
            len = $urandom_range(60, 20);
            calm = (phase == 3);
            for (int unsigned n = 0; n < len; n++) begin
                if (phase == 5 && n == len / 2)
                    wait_drained();
                op.kind = ($urandom_range(99) < add_pct) ? sipq_pkg::KIND_ADD
                                                         : sipq_pkg::KIND_REMOVE;
                // small priority range makes ties common
                r = $urandom_range(9);
                if (r < 4)
                    op.item_prio = 8'($urandom_range(3));
                else if (r == 4)
                    op.item_prio = 8'h00;
                else if (r == 5)
                    op.item_prio = 8'hff;
                else
                    op.item_prio = 8'($urandom());
                op.item_char = 8'($urandom());
                send_op(op);
                sent++;
            end
            calm = 1'b0;
            phase++;
        end
    endtask

    // run limit
    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b0;
        mismatch_count = 0;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_count = 0;
        shadow_capacity = sipq_pkg::CAP_RESET;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed_ops();
        test_capacity_limits();
        test_random_traffic();

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sorted_insert_priority_queue_top.f
+incdir+rtl
rtl/sipq_pkg.sv
rtl/sipq_slot_ram.sv
rtl/sipq_engine.sv
rtl/sorted_insert_priority_queue_top.sv
bench/sorted_insert_priority_queue_top_test.sv
